@@ sv/humidity_temp_frame_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core_defines
// Assertion macros shared by the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define HTFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte step for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned RAW_W   = 20;
  localparam int unsigned HUM_W   = 14;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned HSCL_W  = 14;
  localparam int unsigned TSCL_W  = 15;

  localparam logic [7:0]        CRC_INIT    = 8'hFF;
  localparam logic [7:0]        CRC_POLY    = 8'h31;
  localparam logic [IDX_W-1:0]  LAST_POS    = 3'd6;
  localparam logic [HSCL_W-1:0] HUM_SCALE   = 14'd10000;
  localparam logic [TSCL_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;
  localparam logic [HUM_W-1:0]  HUM_MAX     = 14'd9999;

  typedef struct packed {
    logic             ok;
    logic [RAW_W-1:0] hraw;
    logic [RAW_W-1:0] traw;
  } frame_t;

  // CRC-8, MSB first, one full byte per call
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/htfd_frame_acc.sv @@
// ----------------------------------------------------------------------------
// htfd_frame_acc
// Frame position, running CRC and raw value assembly, one byte per take.
// ----------------------------------------------------------------------------
module htfd_frame_acc (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                done,
  output htfd_pkg::frame_t    frame
);

  logic [htfd_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]                 crc_acc, crc_acc_next;
  logic [htfd_pkg::RAW_W-1:0] humid_raw_acc, humid_raw_acc_next;
  logic [htfd_pkg::RAW_W-1:0] temp_raw_acc, temp_raw_acc_next;

  logic                       restart;
  logic                       last;
  logic [htfd_pkg::IDX_W-1:0] pos;
  logic [7:0]                 crc_cur;
  logic [htfd_pkg::RAW_W-1:0] h_cur, t_cur;

  assign restart = frame_start || (byte_index > htfd_pkg::LAST_POS);
  assign pos     = restart ? '0 : byte_index;
  assign crc_cur = restart ? htfd_pkg::CRC_INIT : crc_acc;
  assign h_cur   = restart ? '0 : humid_raw_acc;
  assign t_cur   = restart ? '0 : temp_raw_acc;
  assign last    = (pos == htfd_pkg::LAST_POS);

  assign done       = take && last;
  assign frame.ok   = (crc_cur == data_byte);
  assign frame.hraw = h_cur;
  assign frame.traw = t_cur;

  always_comb begin
    byte_index_next    = pos + 3'd1;
    crc_acc_next       = htfd_pkg::crc_byte(crc_cur, data_byte);
    humid_raw_acc_next = h_cur;
    temp_raw_acc_next  = t_cur;
    unique case (pos)
      3'd1: humid_raw_acc_next = {data_byte, 12'd0};
      3'd2: humid_raw_acc_next = h_cur | {8'd0, data_byte, 4'd0};
      3'd3: begin
        humid_raw_acc_next = h_cur | {16'd0, data_byte[7:4]};
        temp_raw_acc_next  = {data_byte[3:0], 16'd0};
      end
      3'd4: temp_raw_acc_next = t_cur | {4'd0, data_byte, 8'd0};
      3'd5: temp_raw_acc_next = t_cur | {12'd0, data_byte};
      default: ;
    endcase
    if (last) begin
      byte_index_next    = '0;
      crc_acc_next       = htfd_pkg::CRC_INIT;
      humid_raw_acc_next = '0;
      temp_raw_acc_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      crc_acc       <= htfd_pkg::CRC_INIT;
      humid_raw_acc <= '0;
      temp_raw_acc  <= '0;
    end else if (take) begin
      byte_index    <= byte_index_next;
      crc_acc       <= crc_acc_next;
      humid_raw_acc <= humid_raw_acc_next;
      temp_raw_acc  <= temp_raw_acc_next;
    end
  end

endmodule

@@ sv/humidity_temp_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes a seven-byte humidity/temperature sensor reply with CRC-8 check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one reply byte per item with
//   frame_start marking byte 0. Bytes 1..5 are assembled into two 20-bit raw
//   values; byte 6 is checked against the running CRC-8 (poly 0x31, init FF).
//   Output channel (out_valid / out_stall) carries one item per frame:
//   crc_ok, humidity_centi and temp_centi, values zero on a CRC mismatch.
//   Throughput: one byte per cycle while in_stall is low.
//   Result path: the frame register loads at the edge that accepts byte 6,
//   then the scaling multipliers feed the output register once it is free
//   (not holding a stalled result).
//   Receiver stall: the output register holds; one more frame result waits in
//   the frame register, and in_stall rises only when both are occupied.
//   Reset: frame position cleared, CRC set to FF, no result pending.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_core_defines.svh"

module humidity_temp_frame_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               crc_ok,
  output logic [13:0]        humidity_centi,
  output logic signed [14:0] temp_centi
);

  logic             take;
  logic             done;
  htfd_pkg::frame_t frame;

  logic             s1_valid;
  htfd_pkg::frame_t s1;
  logic             out_free;
  logic             s1_adv;

  logic [htfd_pkg::RAW_W+htfd_pkg::HSCL_W-1:0] hum_prod;
  logic [htfd_pkg::RAW_W+htfd_pkg::TSCL_W-1:0] temp_prod;
  logic [htfd_pkg::HUM_W-1:0]                  hum_val;
  logic [htfd_pkg::TEMP_W-1:0]                 temp_val;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign take     = in_valid && !in_stall;

  htfd_frame_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .done        (done),
    .frame       (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (done) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      s1 <= frame;
    end
  end

  assign hum_prod  = s1.hraw * htfd_pkg::HUM_SCALE;
  assign temp_prod = s1.traw * htfd_pkg::TEMP_SCALE;
  assign hum_val   = s1.ok ? hum_prod[htfd_pkg::RAW_W +: htfd_pkg::HUM_W] : '0;
  assign temp_val  = s1.ok ?
                     (temp_prod[htfd_pkg::RAW_W +: htfd_pkg::TEMP_W] - htfd_pkg::TEMP_OFFSET)
                     : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      crc_ok         <= s1.ok;
      humidity_centi <= hum_val;
      temp_centi     <= $signed(temp_val);
    end
  end

  `HTFD_ASSERT_NEXT(a_done_loads_s1, done, s1_valid, "frame end did not load frame register")
  `HTFD_ASSERT_NEXT(a_adv_loads_out, s1_adv, out_valid, "frame register advance lost result")
  `HTFD_ASSERT_NOW(a_bad_crc_zero, out_valid && !crc_ok,
    (humidity_centi == '0) && (temp_centi == '0), "nonzero values on CRC failure")
  `HTFD_ASSERT_NOW(a_range, out_valid && crc_ok,
    (humidity_centi <= htfd_pkg::HUM_MAX) && (temp_centi >= -$signed(htfd_pkg::TEMP_OFFSET)),
    "scaled value out of range")

endmodule
